[rtl/sevseg_pkg.sv]
// Shared types, constants and segment table for the seven-segment frame sender
`default_nettype none

package sevseg_pkg;

	// default geometry of the frame and the display
	localparam int FRAME_BITS_DEF  = 18;
	localparam int DIGIT_COUNT_DEF = 4;

	// fixed frame layout
	localparam int SEL_BITS   = 4;
	localparam int SEG_BITS   = 8;
	localparam int SEG_SHIFT  = 10;
	localparam int FULL_W     = 32;
	localparam int SYM_W      = 5;
	localparam int POS_W      = 2;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_BIT_LO,
		ST_BIT_HI,
		ST_LATCH0,
		ST_LATCH1,
		ST_LATCH2,
		ST_LATCH3,
		ST_LATCH4
	} state_t;

	// source of the data pin level
	typedef enum logic [1:0] {
		DSRC_ZERO,
		DSRC_ONE,
		DSRC_BIT
	} data_src_t;

	// controller to datapath commands
	typedef struct packed {
		logic      load;
		logic      shift;
		logic      valid;
		logic      clk_lvl;
		data_src_t dsrc;
		logic      last;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last_bit;
	} status_t;

	// segment pattern for a symbol code; codes past the table are blank
	function automatic logic [SEG_BITS-1:0] seg_lookup(input logic [SYM_W-1:0] sym);
		logic [SEG_BITS-1:0] seg;
		case (sym)
			5'd0:    seg = 8'h3F;
			5'd1:    seg = 8'h06;
			5'd2:    seg = 8'h5B;
			5'd3:    seg = 8'h4F;
			5'd4:    seg = 8'h66;
			5'd5:    seg = 8'h6D;
			5'd6:    seg = 8'h7D;
			5'd7:    seg = 8'h07;
			5'd8:    seg = 8'h7F;
			5'd9:    seg = 8'h6F;
			5'd10:   seg = 8'h77;
			5'd11:   seg = 8'h7C;
			5'd12:   seg = 8'h39;
			5'd13:   seg = 8'h5E;
			5'd14:   seg = 8'h79;
			5'd15:   seg = 8'h71;
			5'd16:   seg = 8'h00;
			5'd17:   seg = 8'h54;
			5'd18:   seg = 8'h58;
			5'd19:   seg = 8'h1C;
			5'd20:   seg = 8'h38;
			5'd21:   seg = 8'h31;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

[rtl/seven_segment_serial_frame_sender_unit.sv]
// Top level of the seven-segment serial frame sender
// The first pin phase appears in the cycle after a request is taken.
// A frame gives 2*FRAME_BITS+6 phases (42 by default), one per cycle, set by the
// phase sequencer; a new request is taken on the final phase, so frames run
// back to back. The receiver cannot stall.
// Reset (arst_n low) returns the sequencer to idle and drops any frame in flight.
`default_nettype none

module seven_segment_serial_frame_sender_unit
	import sevseg_pkg::*;
#(
	parameter int FRAME_BITS  = FRAME_BITS_DEF,
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  wire [POS_W-1:0] digit_position,
	input  wire [SYM_W-1:0] symbol_code,
	output logic            phase_valid,
	output logic            clock_level,
	output logic            data_level,
	output logic            last_phase
);

	cmd_t    cmd;
	status_t status;

	sevseg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	sevseg_dp #(
		.FRAME_BITS  (FRAME_BITS),
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.digit_position (digit_position),
		.symbol_code    (symbol_code),
		.phase_valid    (phase_valid),
		.clock_level    (clock_level),
		.data_level     (data_level),
		.last_phase     (last_phase)
	);

endmodule

`default_nettype wire

[rtl/sevseg_ctrl.sv]
// Phase sequencer for the serial frame: start, bit phases and latch phases
`default_nettype none

module sevseg_ctrl
	import sevseg_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	output logic         busy,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;

	// hold the phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance through the phases and drive the datapath commands
	always_comb begin
		state_d     = state_q;
		busy        = 1'b1;
		cmd.load    = 1'b0;
		cmd.shift   = 1'b0;
		cmd.valid   = 1'b1;
		cmd.clk_lvl = 1'b0;
		cmd.dsrc    = DSRC_ZERO;
		cmd.last    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				cmd.valid = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				cmd.dsrc = DSRC_ONE;
				state_d  = ST_BIT_LO;
			end
			ST_BIT_LO: begin
				cmd.dsrc = DSRC_BIT;
				state_d  = ST_BIT_HI;
			end
			ST_BIT_HI: begin
				cmd.clk_lvl = 1'b1;
				cmd.dsrc    = DSRC_BIT;
				cmd.shift   = 1'b1;
				state_d     = status.last_bit ? ST_LATCH0 : ST_BIT_LO;
			end
			ST_LATCH0: begin
				cmd.clk_lvl = 1'b1;
				state_d     = ST_LATCH1;
			end
			ST_LATCH1: begin
				cmd.clk_lvl = 1'b1;
				cmd.dsrc    = DSRC_ONE;
				state_d     = ST_LATCH2;
			end
			ST_LATCH2: begin
				cmd.clk_lvl = 1'b1;
				state_d     = ST_LATCH3;
			end
			ST_LATCH3: begin
				state_d = ST_LATCH4;
			end
			ST_LATCH4: begin
				// take the next request on the final phase
				busy     = 1'b0;
				cmd.dsrc = DSRC_ONE;
				cmd.last = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				cmd.valid = 1'b0;
				state_d   = ST_IDLE;
			end
		endcase
	end

	// a request always opens with the start phase
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_START && cmd.valid))
		else $error("request not followed by start phase");

	// a bit phase pair repeats until the last frame bit
	a_bit_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIT_HI && !status.last_bit) |=> (state_q == ST_BIT_LO))
		else $error("bit loop left early");

	// the latch opens only after the last frame bit
	a_latch_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIT_HI && status.last_bit) |=> (state_q == ST_LATCH0))
		else $error("latch not entered after last bit");

	// no new request while a frame is mid-flight
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && !cmd.last) |-> (busy && !cmd.load))
		else $error("request taken mid-frame");

endmodule

`default_nettype wire

[rtl/sevseg_dp.sv]
// Frame build, bit shift register, bit counter and pin level selection
`default_nettype none

module sevseg_dp
	import sevseg_pkg::*;
#(
	parameter int FRAME_BITS  = FRAME_BITS_DEF,
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire cmd_t        cmd,
	output status_t          status,
	input  wire  [POS_W-1:0] digit_position,
	input  wire  [SYM_W-1:0] symbol_code,
	output logic             phase_valid,
	output logic             clock_level,
	output logic             data_level,
	output logic             last_phase
);

	localparam int CNT_W = $clog2(FRAME_BITS);

	logic [SEL_BITS-1:0]   sel;
	logic [SEG_BITS-1:0]   seg;
	logic [FULL_W-1:0]     frame_full;
	logic [FRAME_BITS-1:0] frame_q;
	logic [CNT_W-1:0]      cnt_q;

	// build the frame: active-low digit select and segment pattern
	always_comb begin
		sel = {SEL_BITS{1'b1}};
		if ({1'b0, digit_position} < (POS_W + 1)'(DIGIT_COUNT)) begin
			sel[digit_position] = 1'b0;
		end
		seg        = seg_lookup(symbol_code);
		frame_full = FULL_W'({seg, {(SEG_SHIFT - SEL_BITS){1'b0}}, sel});
	end

	// load the frame, then drop one bit per bit phase pair
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame_q <= frame_full[FRAME_BITS-1:0];
		end else if (cmd.shift) begin
			frame_q <= frame_q >> 1;
		end
	end

	// count sent bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign status.last_bit = (cnt_q == CNT_W'(FRAME_BITS - 1));

	// select the pin levels for this phase
	always_comb begin
		case (cmd.dsrc)
			DSRC_ZERO: data_level = 1'b0;
			DSRC_ONE:  data_level = 1'b1;
			DSRC_BIT:  data_level = frame_q[0];
			default:   data_level = 1'b0;
		endcase
	end

	assign phase_valid = cmd.valid;
	assign clock_level = cmd.clk_lvl;
	assign last_phase  = cmd.last;

endmodule

`default_nettype wire

[sim/sevseg_frame_checker.sv]
// Frame checker for the seven-segment serial frame sender: predicts pin phases and compares
module sevseg_frame_checker
	import sevseg_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire             busy,
	input  wire [POS_W-1:0] digit_position,
	input  wire [SYM_W-1:0] symbol_code,
	input  wire             phase_valid,
	input  wire             clock_level,
	input  wire             data_level,
	input  wire             last_phase,
	output int              pending_phases,
	output int              mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// one pin phase as seen on the serial clock and data pins
	typedef struct packed {
		logic clock_lvl;
		logic data_lvl;
		logic last;
	} pin_phase_t;

	localparam int GLYPH_COUNT = 22;
	localparam int SENT_BITS   = (FRAME_BITS_DEF > FULL_W) ? FULL_W : FRAME_BITS_DEF;

	// segment patterns: hex digits, blank, then n c u L r
	localparam logic [SEG_BITS-1:0] GLYPHS [GLYPH_COUNT] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
		8'h00, 8'h54, 8'h58, 8'h1C, 8'h38, 8'h31
	};

	pin_phase_t expected_phases[$];
	int         phases_seen;

	initial begin
		pending_phases = 0;
		mismatch_count = 0;
		phases_seen    = 0;
	end

	// print one line per mismatch and count it
	task automatic report_mismatch(input string what);
		$display("%0t ns: phase %0d: %s", $time, phases_seen, what);
		mismatch_count++;
	endtask

	function automatic pin_phase_t make_phase(input logic c, input logic d, input logic l);
		pin_phase_t p;
		p.clock_lvl = c;
		p.data_lvl  = d;
		p.last      = l;
		return p;
	endfunction

	// build the frame for a request and queue every pin phase it drives
	task automatic queue_frame_phases(input logic [POS_W-1:0] pos, input logic [SYM_W-1:0] sym);
		logic [SEL_BITS-1:0] select_n;
		logic [SEG_BITS-1:0] segments;
		logic [FULL_W-1:0]   frame;
		select_n = '1;
		segments = '0;
		if (pos < DIGIT_COUNT_DEF)
			select_n[pos] = 1'b0;
		if (sym < GLYPH_COUNT)
			segments = GLYPHS[sym];
		frame = '0;
		frame[SEL_BITS-1:0] = select_n;
		frame[SEG_SHIFT +: SEG_BITS] = segments;

		expected_phases.push_back(make_phase(1'b0, 1'b1, 1'b0));
		for (int i = 0; i < SENT_BITS; i++) begin
			expected_phases.push_back(make_phase(1'b0, frame[i], 1'b0));
			expected_phases.push_back(make_phase(1'b1, frame[i], 1'b0));
		end
		// latch pulse on data while the clock is high, then park the pins
		expected_phases.push_back(make_phase(1'b1, 1'b0, 1'b0));
		expected_phases.push_back(make_phase(1'b1, 1'b1, 1'b0));
		expected_phases.push_back(make_phase(1'b1, 1'b0, 1'b0));
		expected_phases.push_back(make_phase(1'b0, 1'b0, 1'b0));
		expected_phases.push_back(make_phase(1'b0, 1'b1, 1'b1));
	endtask

	// compare each strobed phase with the oldest prediction, then take new requests
	always @(posedge clk) begin
		pin_phase_t want;
		if (arst_n) begin
			if (phase_valid === 1'b1) begin
				if (expected_phases.size() == 0) begin
					report_mismatch($sformatf("phase with no request outstanding (clk %b data %b last %b)",
						clock_level, data_level, last_phase));
				end else begin
					want = expected_phases.pop_front();
					if (clock_level !== want.clock_lvl)
						report_mismatch($sformatf("clock_level %b, expected %b",
							clock_level, want.clock_lvl));
					if (data_level !== want.data_lvl)
						report_mismatch($sformatf("data_level %b, expected %b",
							data_level, want.data_lvl));
					if (last_phase !== want.last)
						report_mismatch($sformatf("last_phase %b, expected %b",
							last_phase, want.last));
				end
				phases_seen++;
			end
			if (start === 1'b1 && busy === 1'b0)
				queue_frame_phases(digit_position, symbol_code);
		end
		pending_phases = expected_phases.size();
	end

endmodule

[sim/tb_seven_segment_serial_frame_sender_unit.sv]
// Testbench top for the seven-segment serial frame sender: request stimulus and verdict
module tb_seven_segment_serial_frame_sender_unit
	import sevseg_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_ITEMS  = 456;
	localparam int STRETCH_ITEMS = 40;
	localparam int MAX_GAP       = 8;
	localparam int DRAIN_CYCLES  = 50;
	localparam int SYMBOL_MAX    = (1 << SYM_W) - 1;
	localparam int POSITION_MAX  = (1 << POS_W) - 1;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [POS_W-1:0] digit_position = '0;
	logic [SYM_W-1:0] symbol_code = '0;
	logic             busy;
	logic             phase_valid;
	logic             clock_level;
	logic             data_level;
	logic             last_phase;
	int               pending_phases;
	int               mismatch_count;
	bit               quiet_stretch;

	seven_segment_serial_frame_sender_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.digit_position (digit_position),
		.symbol_code    (symbol_code),
		.phase_valid    (phase_valid),
		.clock_level    (clock_level),
		.data_level     (data_level),
		.last_phase     (last_phase)
	);

	sevseg_frame_checker frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.digit_position (digit_position),
		.symbol_code    (symbol_code),
		.phase_valid    (phase_valid),
		.clock_level    (clock_level),
		.data_level     (data_level),
		.last_phase     (last_phase),
		.pending_phases (pending_phases),
		.mismatch_count (mismatch_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hold a request until it is taken; outside quiet stretches, maybe idle a random number of cycles
	task automatic send_request(input logic [POS_W-1:0] pos, input logic [SYM_W-1:0] sym);
		bit taken;
		int gap;
		bit after_frame;
		start          <= 1'b1;
		digit_position <= pos;
		symbol_code    <= sym;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		gap         = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
		after_frame = quiet_stretch ? 1'b0 : 1'($urandom_range(0, 1));
		if (gap > 0 || after_frame) begin
			start <= 1'b0;
			// let the frame run out first so the gap falls on an idle block
			if (after_frame) begin
				do @(negedge clk); while (busy);
				@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
	endtask

	// timeout guard
	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		quiet_stretch = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk every table symbol across the digit positions, back to back
		for (int s = 0; s <= 21; s++)
			send_request(POS_W'(s % (POSITION_MAX + 1)), SYM_W'(s));
		// symbols past the table at both position extremes
		send_request(POS_W'(POSITION_MAX), SYM_W'(SYMBOL_MAX));
		send_request('0, SYM_W'(22));

		// random requests in stretches, some of them without any idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % STRETCH_ITEMS == 0)
				quiet_stretch = ($urandom_range(0, 3) == 0);
			send_request(POS_W'($urandom_range(0, POSITION_MAX)),
				SYM_W'($urandom_range(0, SYMBOL_MAX)));
		end
		start <= 1'b0;

		// drain outstanding phases, then watch for strays
		do @(negedge clk); while (pending_phases != 0);
		@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
